### rtl/lfu_pkg.sv
// Shared constants and controller/datapath interface types for the LFU cache table.
package lfu_pkg;

	// Table geometry.
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_W  = $clog2(ENTRIES + 1);

	// Field widths.
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;
	localparam int CAP_W = 5;
	localparam int CMP_W = (USED_W > CAP_W) ? USED_W : CAP_W;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Request codes.
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic lookup;
		logic scan_step;
		logic evict;
		logic insert;
		logic apply;
		logic load_out;
	} lfu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic put_off;
		logic full;
		logic is_put;
		logic scan_last;
	} lfu_stat_t;

endpackage

### rtl/lfu_ctrl.sv
// Controller state machine that sequences lookup, victim scan, update and result hand-off.
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_stall,
	input  lfu_pkg::lfu_stat_t stat,
	output logic              in_stall,
	output logic              out_valid,
	output lfu_pkg::lfu_cmd_t  cmd
);
	import lfu_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOOKUP = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_EVICT  = 7'b0001000,
		ST_INSERT = 7'b0010000,
		ST_APPLY  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} lfu_state_t;

	lfu_state_t state_q;
	lfu_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a new word when it is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				priority if (stat.put_off) begin
					state_d = ST_DONE;
				end else if (stat.hit) begin
					state_d = ST_APPLY;
				end else if (!stat.is_put) begin
					state_d = ST_DONE;
				end else if (stat.full) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_DONE;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### rtl/lfu_dp.sv
// Datapath: entry table, key match, victim scan, recency/count updates and output register.
module lfu_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lfu_pkg::lfu_cmd_t                    cmd,
	output lfu_pkg::lfu_stat_t                   stat,
	input  logic                                 cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0]            cfg_wr_data,
	input  logic                                 req_type,
	input  logic signed [lfu_pkg::KEY_W-1:0]     lookup_key,
	input  logic signed [lfu_pkg::VAL_W-1:0]     write_value,
	output logic                                 hit,
	output logic signed [lfu_pkg::VAL_W-1:0]     read_data
);
	import lfu_pkg::*;

	// Configuration and captured request.
	logic [CAP_W-1:0]  capacity_q;
	logic              req_put_q;
	logic [KEY_W-1:0]  req_key_q;
	logic [VAL_W-1:0]  req_val_q;

	// Entry table.
	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q  [ENTRIES];
	logic [VAL_W-1:0]   val_q  [ENTRIES];
	logic [CNT_W-1:0]   cnt_q  [ENTRIES];
	logic [IDX_W-1:0]   rank_q [ENTRIES];
	logic [USED_W-1:0]  used_q;

	// Lookup results and pending result word.
	logic [IDX_W-1:0]  hit_idx_q;
	logic              pend_hit_q;
	logic [VAL_W-1:0]  pend_data_q;

	// Victim scan state.
	logic [IDX_W-1:0]  scan_idx_q;
	logic              vic_found_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [CNT_W-1:0]  vic_cnt_q;
	logic [IDX_W-1:0]  vic_rank_q;

	// Output register.
	logic              out_hit_q;
	logic [VAL_W-1:0]  out_data_q;

	// Combinational helpers.
	logic [ENTRIES-1:0] match;
	logic               any_match;
	logic [IDX_W-1:0]   match_idx;
	logic [VAL_W-1:0]   match_val;
	logic               free_any;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   sel_idx;
	logic [CNT_W-1:0]   sel_cnt;
	logic [IDX_W-1:0]   sel_rank;
	logic [CNT_W-1:0]   cnt_inc;
	logic               put_off;
	logic               better;

	// Parallel key compare against all valid entries, first match wins.
	always_comb begin
		match_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == req_key_q);
			if (match[i]) begin
				match_idx = IDX_W'(i);
			end
		end
	end

	assign any_match = |match;
	assign match_val = val_q[match_idx];

	// Lowest-numbered free slot.
	always_comb begin
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign free_any = !(&valid_q);

	// One shared read port on counts and ranks: scan index while scanning, hit index otherwise.
	assign sel_idx  = cmd.scan_step ? scan_idx_q : hit_idx_q;
	assign sel_cnt  = cnt_q[sel_idx];
	assign sel_rank = rank_q[sel_idx];
	assign cnt_inc  = (sel_cnt == {CNT_W{1'b1}}) ? sel_cnt : sel_cnt + CNT_W'(1);

	// Scanned entry replaces the current victim if its count is lower, or equal and older.
	assign better = valid_q[scan_idx_q] &&
		(!vic_found_q || (sel_cnt < vic_cnt_q) ||
		 ((sel_cnt == vic_cnt_q) && (sel_rank > vic_rank_q)));

	// A put with zero capacity changes nothing.
	assign put_off = (req_put_q == REQ_PUT) && (capacity_q == '0);

	// Status toward the controller.
	always_comb begin
		stat.hit       = any_match;
		stat.put_off   = put_off;
		stat.is_put    = (req_put_q == REQ_PUT);
		stat.full      = (CMP_W'(used_q) >= CMP_W'(capacity_q)) ||
		                 (used_q == USED_W'(ENTRIES));
		stat.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));
	end

	// Control state: capacity, valid bits, fill count and scan progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			valid_q     <= '0;
			used_q      <= '0;
			scan_idx_q  <= '0;
			vic_found_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (cmd.capture) begin
				scan_idx_q  <= '0;
				vic_found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (better) begin
					vic_found_q <= 1'b1;
				end
			end
			if (cmd.evict && vic_found_q) begin
				valid_q[vic_idx_q] <= 1'b0;
				used_q             <= used_q - USED_W'(1);
			end
			if (cmd.insert && free_any) begin
				valid_q[free_idx] <= 1'b1;
				used_q            <= used_q + USED_W'(1);
			end
		end
	end

	// Payload: request, table contents, victim copy and result words.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_put_q <= req_type;
			req_key_q <= lookup_key;
			req_val_q <= write_value;
		end
		if (cmd.lookup) begin
			hit_idx_q   <= match_idx;
			pend_hit_q  <= any_match && !put_off;
			pend_data_q <= (any_match && (req_put_q == REQ_GET)) ? match_val : '0;
		end
		if (cmd.scan_step && better) begin
			vic_idx_q  <= scan_idx_q;
			vic_cnt_q  <= sel_cnt;
			vic_rank_q <= sel_rank;
		end
		// Recency ranks shift around the entry being removed, inserted or touched.
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.evict && vic_found_q && valid_q[i] && (rank_q[i] > vic_rank_q)) begin
				rank_q[i] <= rank_q[i] - IDX_W'(1);
			end
			if (cmd.insert && free_any && valid_q[i]) begin
				rank_q[i] <= rank_q[i] + IDX_W'(1);
			end
			if (cmd.apply && valid_q[i] && (rank_q[i] < sel_rank)) begin
				rank_q[i] <= rank_q[i] + IDX_W'(1);
			end
		end
		// A hit becomes most recent and its count rises, saturating.
		if (cmd.apply) begin
			rank_q[hit_idx_q] <= '0;
			cnt_q[hit_idx_q]  <= cnt_inc;
			if (req_put_q == REQ_PUT) begin
				val_q[hit_idx_q] <= req_val_q;
			end
		end
		// A new entry goes into the lowest free slot as most recent with count one.
		if (cmd.insert && free_any) begin
			key_q[free_idx]  <= req_key_q;
			val_q[free_idx]  <= req_val_q;
			cnt_q[free_idx]  <= CNT_W'(1);
			rank_q[free_idx] <= '0;
		end
		if (cmd.load_out) begin
			out_hit_q  <= pend_hit_q;
			out_data_q <= pend_data_q;
		end
	end

	assign hit       = out_hit_q;
	assign read_data = $signed(out_data_q);

endmodule

### rtl/lfu_cache_table.sv
// Top level of the LFU cache table: controller plus datapath.
//
// A fully associative 16-entry key/value cache with least-frequently-used
// replacement; among equal use counts the least recently used entry goes.
// The input channel (in_valid/in_stall) carries one request word: req_type
// (get or put), lookup_key and write_value. The output channel
// (out_valid/out_stall) returns one word per request: hit and read_data.
// The capacity register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, as the block does not enforce this. One
// request is worked on at a time. A hit is applied and a put miss inserted
// before the result goes out, on a full table after a victim scan that reads
// one entry's count and rank per cycle through a single read port and an
// eviction. in_stall is high from acceptance until the result word moves
// into the output register. If the receiver stalls, the result waits in the
// output register while the next request is already accepted and worked on;
// that one then holds until the output register is free. Reset clears all
// valid bits and sets the capacity to 16; no clearing pass is needed.
module lfu_cache_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0]        cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             req_type,
	input  logic signed [lfu_pkg::KEY_W-1:0] lookup_key,
	input  logic signed [lfu_pkg::VAL_W-1:0] write_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic signed [lfu_pkg::VAL_W-1:0] read_data
);
	import lfu_pkg::*;

	lfu_cmd_t  cmd;
	lfu_stat_t stat;

	// Sequencing.
	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Table and arithmetic.
	lfu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.hit         (hit),
		.read_data   (read_data)
	);

endmodule
